// File: hw/rtl/tee_pkg.sv
// Shared types and constants for the triangle edge extrusion block.
package tee_pkg;

   localparam int MaxVertices = 1024;
   localparam int QueueDepth  = 2;
   localparam int QueuePtrW   = $clog2(QueueDepth);
   localparam int QueueCntW   = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic [31:0] point_a;
      logic [31:0] point_b;
      logic [31:0] point_c;
      logic        ab_ext;
      logic        bc_ext;
      logic        ca_ext;
      logic        final_tri;
   } tee_item_type;

endpackage

// File: hw/rtl/tee_front.sv
// Front end: takes a triangle beat and classifies its edges against the outline.
module tee_front (
   input  logic                  start,
   output logic                  busy,
   input  logic [31:0]           req_point_a,
   input  logic [31:0]           req_point_b,
   input  logic [31:0]           req_point_c,
   input  logic signed [10:0]    req_a_index,
   input  logic signed [10:0]    req_a_next,
   input  logic signed [10:0]    req_b_index,
   input  logic signed [10:0]    req_b_next,
   input  logic signed [10:0]    req_c_index,
   input  logic signed [10:0]    req_c_next,
   input  logic                  req_final_triangle,
   input  logic                  q_full,
   output logic                  q_push,
   output tee_pkg::tee_item_type q_item
);

   function automatic logic valid_idx(input logic signed [10:0] i);
      return !i[10] && ({22'd0, i[9:0]} < 32'(tee_pkg::MaxVertices));
   endfunction

   function automatic logic adjacent(input logic signed [10:0] ia, input logic signed [10:0] na,
                                     input logic signed [10:0] ib, input logic signed [10:0] nb);
      return valid_idx(ia) && valid_idx(ib) && ((na == ib) || (nb == ia));
   endfunction

   assign busy   = q_full;
   assign q_push = start && !q_full;

   always_comb begin
      q_item.point_a   = req_point_a;
      q_item.point_b   = req_point_b;
      q_item.point_c   = req_point_c;
      q_item.ab_ext    = adjacent(req_a_index, req_a_next, req_b_index, req_b_next);
      q_item.bc_ext    = adjacent(req_b_index, req_b_next, req_c_index, req_c_next);
      q_item.ca_ext    = adjacent(req_c_index, req_c_next, req_a_index, req_a_next);
      q_item.final_tri = req_final_triangle;
   end

endmodule

// File: hw/rtl/tee_queue.sv
// Short queue of classified triangles between front and back end.
module tee_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tee_pkg::tee_item_type push_item,
   output logic                  full,
   output logic                  valid,
   output tee_pkg::tee_item_type item,
   input  logic                  pop
);

   tee_pkg::tee_item_type mem_ff [tee_pkg::QueueDepth];
   logic [tee_pkg::QueuePtrW-1:0] wp_ff, rp_ff;
   logic [tee_pkg::QueueCntW-1:0] cnt_ff;

   assign full  = (cnt_ff == tee_pkg::QueueCntW'(tee_pkg::QueueDepth));
   assign valid = (cnt_ff != '0);
   assign item  = mem_ff[rp_ff];

   function automatic logic [tee_pkg::QueuePtrW-1:0] bump(input logic [tee_pkg::QueuePtrW-1:0] p);
      return (p == tee_pkg::QueuePtrW'(tee_pkg::QueueDepth - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_item;
      end
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= bump(wp_ff);
         if (pop)  rp_ff <= bump(rp_ff);
         if (push && !pop)      cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

endmodule

// File: hw/rtl/tee_back.sv
// Back end: sequencer with shared multiplier, bit-serial square root and divider.
module tee_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  tee_pkg::tee_item_type q_item,
   output logic                  q_pop,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_corner_slot,
   output logic                  rsp_corner_last,
   output logic                  rsp_glyph_end,
   output logic signed [23:0]    rsp_tri_normal_x,
   output logic signed [23:0]    rsp_tri_normal_y,
   output logic signed [23:0]    rsp_edge_normal_x,
   output logic signed [23:0]    rsp_edge_normal_y,
   output logic signed [23:0]    rsp_height_factor,
   output logic                  rsp_ab_exterior,
   output logic                  rsp_bc_exterior,
   output logic                  rsp_ca_exterior,
   output logic                  rsp_saturated
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MUL1  = 4'd1;
   localparam logic [3:0] ST_MUL2  = 4'd2;
   localparam logic [3:0] ST_ADD   = 4'd3;
   localparam logic [3:0] ST_SQRT  = 4'd4;
   localparam logic [3:0] ST_PREP  = 4'd5;
   localparam logic [3:0] ST_DLOAD = 4'd6;
   localparam logic [3:0] ST_DIV   = 4'd7;
   localparam logic [3:0] ST_STORE = 4'd8;
   localparam logic [3:0] ST_OUT   = 4'd9;

   localparam logic [2:0] MODE_NORM   = 3'd0;
   localparam logic [2:0] MODE_MITER  = 3'd1;
   localparam logic [2:0] MODE_PROJ   = 3'd2;
   localparam logic [2:0] MODE_ZERO   = 3'd3;
   localparam logic [2:0] MODE_HEIGHT = 3'd4;

   localparam logic [3:0] OP_NRM0 = 4'd0;
   localparam logic [3:0] OP_NRM1 = 4'd1;
   localparam logic [3:0] OP_NRM2 = 4'd2;
   localparam logic [3:0] OP_TRI0 = 4'd3;
   localparam logic [3:0] OP_TRI1 = 4'd4;
   localparam logic [3:0] OP_TRI2 = 4'd5;
   localparam logic [3:0] OP_EDG0 = 4'd6;
   localparam logic [3:0] OP_EDG1 = 4'd7;
   localparam logic [3:0] OP_EDG2 = 4'd8;
   localparam logic [3:0] OP_HGT0 = 4'd9;
   localparam logic [3:0] OP_HGT1 = 4'd10;
   localparam logic [3:0] OP_HGT2 = 4'd11;

   localparam logic [5:0] SqrtLast = 6'd24;
   localparam logic [5:0] DivLast  = 6'd51;

   localparam logic signed [51:0] SatMax = 52'sd8388607;
   localparam logic signed [51:0] SatMin = -52'sd8388608;

   function automatic logic signed [51:0] sx52(input logic signed [24:0] v);
      return {{27{v[24]}}, v};
   endfunction

   function automatic logic signed [24:0] sx17(input logic signed [16:0] v);
      return {{8{v[16]}}, v};
   endfunction

   function automatic logic signed [24:0] sx24(input logic signed [23:0] v);
      return {v[23], v};
   endfunction

   // round to nearest, ties away from zero, of v / 2^16
   function automatic logic signed [51:0] rnd16(input logic signed [51:0] v);
      logic [51:0] mag;
      logic [51:0] q;
      mag = v[51] ? 52'(-v) : 52'(v);
      q   = ({mag[50:0], 1'b0} + 52'd65536) >> 17;
      return v[51] ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic sat_ovf(input logic signed [51:0] v);
      return (v > SatMax) || (v < SatMin);
   endfunction

   function automatic logic signed [23:0] sat_val(input logic signed [51:0] v);
      logic signed [23:0] r;
      if (v > SatMax)      r = SatMax[23:0];
      else if (v < SatMin) r = SatMin[23:0];
      else                 r = v[23:0];
      return r;
   endfunction

   function automatic logic signed [23:0] sat_sign(input logic signed [51:0] v);
      logic signed [23:0] r;
      if (v[51])          r = SatMin[23:0];
      else if (v != '0)   r = SatMax[23:0];
      else                r = '0;
      return r;
   endfunction

   logic [3:0]            state_ff, state_in;
   logic [3:0]            op_ff;
   logic [1:0]            slot_ff;
   logic [5:0]            cnt_ff;
   logic                  which_ff;
   logic                  sat_ff;
   tee_pkg::tee_item_type it_ff;

   logic signed [49:0]    p_ff;
   logic signed [51:0]    acc_ff;
   logic [49:0]           sq_v_ff;
   logic [27:0]           sq_rem_ff;
   logic [24:0]           sq_root_ff;
   logic signed [51:0]    num_x_ff, num_y_ff;
   logic [39:0]           d_ff;
   logic [51:0]           dn_ff;
   logic [40:0]           dv_ff;
   logic [40:0]           rem_ff;
   logic                  neg_ff;
   logic signed [23:0]    rx_ff, ry_ff;

   logic signed [23:0]    nx_ff [3];
   logic signed [23:0]    ny_ff [3];
   logic signed [23:0]    tx_ff [3];
   logic signed [23:0]    ty_ff [3];
   logic signed [23:0]    ex_ff [3];
   logic signed [23:0]    ey_ff [3];
   logic signed [23:0]    h_ff  [3];

   // corner coordinates and edge vectors
   logic signed [15:0] ax, ay, bx, by, cx, cy;
   logic signed [16:0] ab_x, ab_y, ac_x, ac_y, cb_x, cb_y, ca_x, ca_y, bc_x, bc_y;

   assign ax = it_ff.point_a[31:16];
   assign ay = it_ff.point_a[15:0];
   assign bx = it_ff.point_b[31:16];
   assign by = it_ff.point_b[15:0];
   assign cx = it_ff.point_c[31:16];
   assign cy = it_ff.point_c[15:0];
   assign ab_x = {bx[15], bx} - {ax[15], ax};
   assign ab_y = {by[15], by} - {ay[15], ay};
   assign ac_x = {cx[15], cx} - {ax[15], ax};
   assign ac_y = {cy[15], cy} - {ay[15], ay};
   assign cb_x = {bx[15], bx} - {cx[15], cx};
   assign cb_y = {by[15], by} - {cy[15], cy};
   assign ca_x = {ax[15], ax} - {cx[15], cx};
   assign ca_y = {ay[15], ay} - {cy[15], cy};
   assign bc_x = {cx[15], cx} - {bx[15], bx};
   assign bc_y = {cy[15], cy} - {by[15], by};

   // operand selection for the current operation
   logic [2:0]         mode;
   logic signed [24:0] ux, uy, vx, vy;
   logic               c_e1, c_e2;
   logic signed [24:0] c_n1x, c_n1y, c_n2x, c_n2y, c_d1x, c_d1y, c_d2x, c_d2y;

   always_comb begin
      c_e1  = 1'b0;
      c_e2  = 1'b0;
      c_n1x = '0; c_n1y = '0; c_n2x = '0; c_n2y = '0;
      c_d1x = '0; c_d1y = '0; c_d2x = '0; c_d2y = '0;
      unique case (op_ff)
         OP_TRI0: begin
            c_e1 = it_ff.ab_ext; c_e2 = it_ff.ca_ext;
            c_n1x = sx24(nx_ff[0]); c_n1y = sx24(ny_ff[0]);
            c_n2x = sx24(nx_ff[1]); c_n2y = sx24(ny_ff[1]);
            c_d1x = sx17(ac_x); c_d1y = sx17(ac_y);
            c_d2x = sx17(ab_x); c_d2y = sx17(ab_y);
         end
         OP_TRI1: begin
            c_e1 = it_ff.ab_ext; c_e2 = it_ff.bc_ext;
            c_n1x = sx24(nx_ff[0]); c_n1y = sx24(ny_ff[0]);
            c_n2x = sx24(nx_ff[2]); c_n2y = sx24(ny_ff[2]);
            c_d1x = sx17(cb_x); c_d1y = sx17(cb_y);
            c_d2x = sx17(ab_x); c_d2y = sx17(ab_y);
         end
         OP_TRI2: begin
            c_e1 = it_ff.ca_ext; c_e2 = it_ff.bc_ext;
            c_n1x = sx24(nx_ff[1]); c_n1y = sx24(ny_ff[1]);
            c_n2x = sx24(nx_ff[2]); c_n2y = sx24(ny_ff[2]);
            c_d1x = sx17(cb_x); c_d1y = sx17(cb_y);
            c_d2x = sx17(ac_x); c_d2y = sx17(ac_y);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      mode = MODE_ZERO;
      ux = '0; uy = '0; vx = '0; vy = '0;
      unique case (op_ff)
         OP_NRM0: begin
            mode = MODE_NORM;
            ux = sx17(ab_x); uy = sx17(ab_y); vx = sx17(ab_x); vy = sx17(ab_y);
         end
         OP_NRM1: begin
            mode = MODE_NORM;
            ux = sx17(ca_x); uy = sx17(ca_y); vx = sx17(ca_x); vy = sx17(ca_y);
         end
         OP_NRM2: begin
            mode = MODE_NORM;
            ux = sx17(bc_x); uy = sx17(bc_y); vx = sx17(bc_x); vy = sx17(bc_y);
         end
         OP_TRI0, OP_TRI1, OP_TRI2: begin
            priority if (c_e1 && c_e2) begin
               mode = MODE_MITER;
               ux = c_n1x; uy = c_n1y; vx = c_n2x; vy = c_n2y;
            end else if (c_e1) begin
               mode = MODE_PROJ;
               ux = c_d1x; uy = c_d1y; vx = c_n1x; vy = c_n1y;
            end else if (c_e2) begin
               mode = MODE_PROJ;
               ux = c_d2x; uy = c_d2y; vx = c_n2x; vy = c_n2y;
            end else begin
               mode = MODE_ZERO;
            end
         end
         OP_EDG0: begin
            mode = MODE_MITER;
            ux = sx24(nx_ff[0]); uy = sx24(ny_ff[0]); vx = sx24(nx_ff[1]); vy = sx24(ny_ff[1]);
         end
         OP_EDG1: begin
            mode = MODE_MITER;
            ux = sx24(nx_ff[0]); uy = sx24(ny_ff[0]); vx = sx24(nx_ff[2]); vy = sx24(ny_ff[2]);
         end
         OP_EDG2: begin
            mode = MODE_MITER;
            ux = sx24(nx_ff[1]); uy = sx24(ny_ff[1]); vx = sx24(nx_ff[2]); vy = sx24(ny_ff[2]);
         end
         OP_HGT0: begin
            mode = MODE_HEIGHT;
            ux = sx24(nx_ff[2]); uy = sx24(ny_ff[2]); vx = sx24(tx_ff[0]); vy = sx24(ty_ff[0]);
         end
         OP_HGT1: begin
            mode = MODE_HEIGHT;
            ux = sx24(nx_ff[1]); uy = sx24(ny_ff[1]); vx = sx24(tx_ff[1]); vy = sx24(ty_ff[1]);
         end
         OP_HGT2: begin
            mode = MODE_HEIGHT;
            ux = sx24(nx_ff[0]); uy = sx24(ny_ff[0]); vx = sx24(tx_ff[2]); vy = sx24(ty_ff[2]);
         end
         default: begin
         end
      endcase
   end

   // divider setup: numerators, positive divisor, zero-divisor flag
   logic signed [51:0] pr_nx, pr_ny, pr_den, pr_h;
   logic [39:0]        pr_d;
   logic               pr_zero;

   always_comb begin
      pr_den  = 52'sd65536 + rnd16(acc_ff);
      pr_h    = -rnd16(acc_ff);
      pr_nx   = '0;
      pr_ny   = '0;
      pr_d    = '0;
      pr_zero = 1'b1;
      unique case (mode)
         MODE_NORM: begin
            pr_nx   = (-sx52(uy)) <<< 24;
            pr_ny   = sx52(ux) <<< 24;
            pr_d    = {15'd0, sq_root_ff};
            pr_zero = (sq_root_ff == '0);
         end
         MODE_MITER: begin
            pr_nx   = (sx52(ux) + sx52(vx)) <<< 16;
            pr_ny   = (sx52(uy) + sx52(vy)) <<< 16;
            pr_d    = pr_den[39:0];
            pr_zero = pr_den[51] || (pr_den == '0);
         end
         MODE_PROJ: begin
            pr_nx   = acc_ff[51] ? -(sx52(ux) <<< 32) : (sx52(ux) <<< 32);
            pr_ny   = acc_ff[51] ? -(sx52(uy) <<< 32) : (sx52(uy) <<< 32);
            pr_d    = acc_ff[51] ? 40'(-acc_ff) : acc_ff[39:0];
            pr_zero = (acc_ff == '0);
         end
         default: begin
         end
      endcase
   end

   // one square-root digit and one quotient bit per cycle
   logic [27:0] sq_sh, sq_trial;
   logic        sq_ge;
   logic [40:0] dv_sh;
   logic        dv_ge;
   logic [51:0] dn_step;
   logic signed [51:0] div_val;
   logic signed [51:0] ld_num;
   logic [51:0] ld_mag;
   logic signed [51:0] sum_len;

   always_comb begin
      sq_sh    = {sq_rem_ff[25:0], sq_v_ff[49:48]};
      sq_trial = {1'b0, sq_root_ff, 2'b01};
      sq_ge    = (sq_sh >= sq_trial);
      dv_sh    = {rem_ff[39:0], dn_ff[51]};
      dv_ge    = (dv_sh >= dv_ff);
      dn_step  = {dn_ff[50:0], dv_ge};
      div_val  = neg_ff ? -$signed(dn_step) : $signed(dn_step);
      ld_num   = which_ff ? num_y_ff : num_x_ff;
      ld_mag   = ld_num[51] ? 52'(-ld_num) : 52'(ld_num);
      sum_len  = acc_ff + {{2{p_ff[49]}}, p_ff};
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (q_valid) state_in = ST_MUL1;
         ST_MUL1:  state_in = (mode == MODE_ZERO) ? ST_STORE : ST_MUL2;
         ST_MUL2:  state_in = ST_ADD;
         ST_ADD:   state_in = (mode == MODE_NORM) ? ST_SQRT : ST_PREP;
         ST_SQRT:  if (cnt_ff == SqrtLast) state_in = ST_PREP;
         ST_PREP: begin
            if (mode == MODE_HEIGHT) state_in = (op_ff == OP_HGT2) ? ST_OUT : ST_MUL1;
            else                     state_in = pr_zero ? ST_STORE : ST_DLOAD;
         end
         ST_DLOAD: state_in = ST_DIV;
         ST_DIV:   if (cnt_ff == DivLast) state_in = which_ff ? ST_STORE : ST_DLOAD;
         ST_STORE: state_in = ST_MUL1;
         ST_OUT:   if (slot_ff == 2'd2) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   assign q_pop = (state_ff == ST_IDLE) && q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_NRM0;
         slot_ff  <= '0;
         cnt_ff   <= '0;
         which_ff <= 1'b0;
         sat_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  it_ff   <= q_item;
                  op_ff   <= OP_NRM0;
                  sat_ff  <= 1'b0;
                  slot_ff <= '0;
               end
            end
            ST_MUL1: begin
               p_ff  <= ux * vx;
               rx_ff <= '0;
               ry_ff <= '0;
            end
            ST_MUL2: begin
               acc_ff <= {{2{p_ff[49]}}, p_ff};
               p_ff   <= uy * vy;
            end
            ST_ADD: begin
               acc_ff     <= sum_len;
               sq_v_ff    <= {sum_len[33:0], 16'd0};
               sq_rem_ff  <= '0;
               sq_root_ff <= '0;
               cnt_ff     <= '0;
            end
            ST_SQRT: begin
               sq_rem_ff  <= sq_ge ? sq_sh - sq_trial : sq_sh;
               sq_root_ff <= {sq_root_ff[23:0], sq_ge};
               sq_v_ff    <= {sq_v_ff[47:0], 2'b00};
               cnt_ff     <= cnt_ff + 1'b1;
            end
            ST_PREP: begin
               if (mode == MODE_HEIGHT) begin
                  unique case (op_ff)
                     OP_HGT0: h_ff[0] <= sat_val(pr_h);
                     OP_HGT1: h_ff[1] <= sat_val(pr_h);
                     default: h_ff[2] <= sat_val(pr_h);
                  endcase
                  if (sat_ovf(pr_h)) sat_ff <= 1'b1;
                  if (op_ff != OP_HGT2) op_ff <= op_ff + 1'b1;
               end else begin
                  num_x_ff <= pr_nx;
                  num_y_ff <= pr_ny;
                  d_ff     <= pr_d;
                  which_ff <= 1'b0;
                  if (pr_zero) begin
                     rx_ff  <= sat_sign(pr_nx);
                     ry_ff  <= sat_sign(pr_ny);
                     sat_ff <= 1'b1;
                  end
               end
            end
            ST_DLOAD: begin
               dn_ff  <= {ld_mag[50:0], 1'b0} + {12'd0, d_ff};
               dv_ff  <= {d_ff, 1'b0};
               rem_ff <= '0;
               neg_ff <= ld_num[51];
               cnt_ff <= '0;
            end
            ST_DIV: begin
               rem_ff <= dv_ge ? dv_sh - dv_ff : dv_sh;
               dn_ff  <= dn_step;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == DivLast) begin
                  if (which_ff) ry_ff <= sat_val(div_val);
                  else          rx_ff <= sat_val(div_val);
                  if (sat_ovf(div_val)) sat_ff <= 1'b1;
                  which_ff <= 1'b1;
               end
            end
            ST_STORE: begin
               unique case (op_ff)
                  OP_NRM0: begin nx_ff[0] <= rx_ff; ny_ff[0] <= ry_ff; end
                  OP_NRM1: begin nx_ff[1] <= rx_ff; ny_ff[1] <= ry_ff; end
                  OP_NRM2: begin nx_ff[2] <= rx_ff; ny_ff[2] <= ry_ff; end
                  OP_TRI0: begin tx_ff[0] <= rx_ff; ty_ff[0] <= ry_ff; end
                  OP_TRI1: begin tx_ff[1] <= rx_ff; ty_ff[1] <= ry_ff; end
                  OP_TRI2: begin tx_ff[2] <= rx_ff; ty_ff[2] <= ry_ff; end
                  OP_EDG0: begin ex_ff[0] <= rx_ff; ey_ff[0] <= ry_ff; end
                  OP_EDG1: begin ex_ff[1] <= rx_ff; ey_ff[1] <= ry_ff; end
                  default: begin ex_ff[2] <= rx_ff; ey_ff[2] <= ry_ff; end
               endcase
               op_ff <= op_ff + 1'b1;
            end
            ST_OUT: begin
               slot_ff <= slot_ff + 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // result beats, one per corner
   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_corner_slot = slot_ff;
   assign rsp_corner_last = (slot_ff == 2'd2);
   assign rsp_glyph_end   = it_ff.final_tri;
   assign rsp_ab_exterior = it_ff.ab_ext;
   assign rsp_bc_exterior = it_ff.bc_ext;
   assign rsp_ca_exterior = it_ff.ca_ext;
   assign rsp_saturated   = sat_ff;

   always_comb begin
      unique case (slot_ff)
         2'd0: begin
            rsp_tri_normal_x  = tx_ff[0]; rsp_tri_normal_y  = ty_ff[0];
            rsp_edge_normal_x = ex_ff[0]; rsp_edge_normal_y = ey_ff[0];
            rsp_height_factor = h_ff[0];
         end
         2'd1: begin
            rsp_tri_normal_x  = tx_ff[1]; rsp_tri_normal_y  = ty_ff[1];
            rsp_edge_normal_x = ex_ff[1]; rsp_edge_normal_y = ey_ff[1];
            rsp_height_factor = h_ff[1];
         end
         default: begin
            rsp_tri_normal_x  = tx_ff[2]; rsp_tri_normal_y  = ty_ff[2];
            rsp_edge_normal_x = ex_ff[2]; rsp_edge_normal_y = ey_ff[2];
            rsp_height_factor = h_ff[2];
         end
      endcase
   end

endmodule

// File: hw/rtl/triangle_edge_extrusion_top.sv
// An accepted beat waits in the queue until the back end is idle; its corner results follow as
// three result beats in slot order, one beat per corner.
// The back end works on one triangle at a time, its pace set by the bit-serial divider (up to
// 18 quotients, each after its own load) and the bit-serial square root.
// A two-entry queue takes up to two more triangles while one is in work; busy marks it full.
// Reset (synchronous, active high) empties the queue and idles the back end; no rsp stall.
module triangle_edge_extrusion_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [31:0]         req_point_a,
   input  logic [31:0]         req_point_b,
   input  logic [31:0]         req_point_c,
   input  logic signed [10:0]  req_a_index,
   input  logic signed [10:0]  req_a_next,
   input  logic signed [10:0]  req_b_index,
   input  logic signed [10:0]  req_b_next,
   input  logic signed [10:0]  req_c_index,
   input  logic signed [10:0]  req_c_next,
   input  logic                req_final_triangle,
   output logic                rsp_valid,
   output logic [1:0]          rsp_corner_slot,
   output logic                rsp_corner_last,
   output logic                rsp_glyph_end,
   output logic signed [23:0]  rsp_tri_normal_x,
   output logic signed [23:0]  rsp_tri_normal_y,
   output logic signed [23:0]  rsp_edge_normal_x,
   output logic signed [23:0]  rsp_edge_normal_y,
   output logic signed [23:0]  rsp_height_factor,
   output logic                rsp_ab_exterior,
   output logic                rsp_bc_exterior,
   output logic                rsp_ca_exterior,
   output logic                rsp_saturated
);

   logic                  q_full, q_push, q_valid, q_pop;
   tee_pkg::tee_item_type push_item, pop_item;

   tee_front u_front (
      .start              (start),
      .busy               (busy),
      .req_point_a        (req_point_a),
      .req_point_b        (req_point_b),
      .req_point_c        (req_point_c),
      .req_a_index        (req_a_index),
      .req_a_next         (req_a_next),
      .req_b_index        (req_b_index),
      .req_b_next         (req_b_next),
      .req_c_index        (req_c_index),
      .req_c_next         (req_c_next),
      .req_final_triangle (req_final_triangle),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_item             (push_item)
   );

   tee_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .valid     (q_valid),
      .item      (pop_item),
      .pop       (q_pop)
   );

   tee_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_item            (pop_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_corner_slot   (rsp_corner_slot),
      .rsp_corner_last   (rsp_corner_last),
      .rsp_glyph_end     (rsp_glyph_end),
      .rsp_tri_normal_x  (rsp_tri_normal_x),
      .rsp_tri_normal_y  (rsp_tri_normal_y),
      .rsp_edge_normal_x (rsp_edge_normal_x),
      .rsp_edge_normal_y (rsp_edge_normal_y),
      .rsp_height_factor (rsp_height_factor),
      .rsp_ab_exterior   (rsp_ab_exterior),
      .rsp_bc_exterior   (rsp_bc_exterior),
      .rsp_ca_exterior   (rsp_ca_exterior),
      .rsp_saturated     (rsp_saturated)
   );

endmodule

// File: verif/triangle_edge_extrusion_top_tb.sv
// Testbench for triangle_edge_extrusion_top: directed table plus random triangles, self-checked.
module triangle_edge_extrusion_top_tb;

   localparam longint SatMax = 64'sd8388607;
   localparam longint SatMin = -64'sd8388608;
   localparam int     Settle = 1200;

   typedef struct {
      longint x;
      longint y;
   } vec_type;

   typedef struct {
      logic [1:0]         slot;
      logic               last;
      logic               glyph_end;
      logic signed [23:0] tri_x;
      logic signed [23:0] tri_y;
      logic signed [23:0] edge_x;
      logic signed [23:0] edge_y;
      logic signed [23:0] height;
      logic               ab_ext;
      logic               bc_ext;
      logic               ca_ext;
      logic               sat;
   } corner_type;

   typedef struct {
      logic [31:0]        pa;
      logic [31:0]        pb;
      logic [31:0]        pc;
      logic signed [10:0] ia;
      logic signed [10:0] na;
      logic signed [10:0] ib;
      logic signed [10:0] nb;
      logic signed [10:0] ic;
      logic signed [10:0] nc;
      logic               fin;
      bit                 typed;
   } tri_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [31:0] req_point_a = '0, req_point_b = '0, req_point_c = '0;
   logic signed [10:0] req_a_index = '0, req_a_next = '0, req_b_index = '0;
   logic signed [10:0] req_b_next = '0, req_c_index = '0, req_c_next = '0;
   logic req_final_triangle = 1'b0;
   logic rsp_valid;
   logic [1:0] rsp_corner_slot;
   logic rsp_corner_last, rsp_glyph_end;
   logic signed [23:0] rsp_tri_normal_x, rsp_tri_normal_y;
   logic signed [23:0] rsp_edge_normal_x, rsp_edge_normal_y, rsp_height_factor;
   logic rsp_ab_exterior, rsp_bc_exterior, rsp_ca_exterior, rsp_saturated;

   corner_type expected_corners[$];
   bit      typed_zero = 1'b0;
   int      beats_taken = 0;
   int      errors = 0;
   int      idle_pct = 0;

   triangle_edge_extrusion_top DUT (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #30000000;
      $display("simulation failed");
      $finish;
   end

   // ---------------- extrusion predictor ----------------
   function automatic longint unsigned isqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint round_div(longint num, longint den);
      longint unsigned mag, q;
      mag = num < 0 ? longint'(-num) : num;
      q = (2 * mag + longint'(den)) / (2 * longint'(den));
      return num < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint clamp24(longint v, inout bit f);
      if (v > SatMax) begin
         f = 1;
         return SatMax;
      end
      if (v < SatMin) begin
         f = 1;
         return SatMin;
      end
      return v;
   endfunction

   function automatic longint sign_rail(longint num, inout bit f);
      f = 1;
      return num > 0 ? SatMax : (num < 0 ? SatMin : 0);
   endfunction

   function automatic vec_type unit_normal(longint dx, longint dy, inout bit f);
      vec_type n;
      longint len;
      n = '{0, 0};
      len = longint'(isqrt((dx * dx + dy * dy) << 16));
      if (len == 0) begin
         f = 1;
         return n;
      end
      n.x = round_div(-dy * 16777216, len);
      n.y = round_div(dx * 16777216, len);
      return n;
   endfunction

   function automatic vec_type miter(vec_type n1, vec_type n2, inout bit f);
      vec_type r;
      longint sx, sy, den;
      sx = n1.x + n2.x;
      sy = n1.y + n2.y;
      den = 65536 + round_div(n1.x * n2.x + n1.y * n2.y, 65536);
      if (den <= 0) begin
         r.x = sign_rail(sx, f);
         r.y = sign_rail(sy, f);
      end else begin
         r.x = clamp24(round_div(sx * 65536, den), f);
         r.y = clamp24(round_div(sy * 65536, den), f);
      end
      return r;
   endfunction

   function automatic vec_type project(vec_type e, vec_type n, inout bit f);
      vec_type r;
      longint dot, nx, ny;
      dot = e.x * n.x + e.y * n.y;
      nx = e.x * 64'sd4294967296;
      ny = e.y * 64'sd4294967296;
      if (dot == 0) begin
         r.x = sign_rail(nx, f);
         r.y = sign_rail(ny, f);
         return r;
      end
      if (dot < 0) begin
         dot = -dot;
         nx = -nx;
         ny = -ny;
      end
      r.x = clamp24(round_div(nx, dot), f);
      r.y = clamp24(round_div(ny, dot), f);
      return r;
   endfunction

   function automatic longint height_of(vec_type n, vec_type t, inout bit f);
      return clamp24(-round_div(n.x * t.x + n.y * t.y, 65536), f);
   endfunction

   function automatic bit on_outline(longint ia, longint na, longint ib, longint nb);
      return ia >= 0 && ia < tee_pkg::MaxVertices && ib >= 0 && ib < tee_pkg::MaxVertices &&
             (na == ib || nb == ia);
   endfunction

   function automatic vec_type corner_vec(bit e1, bit e2, vec_type n1, vec_type n2,
                                          vec_type d1, vec_type d2, inout bit f);
      vec_type z;
      z = '{0, 0};
      if (e1 && e2) return miter(n1, n2, f);
      if (e1) return project(d1, n1, f);
      if (e2) return project(d2, n2, f);
      return z;
   endfunction

   function automatic longint coord(logic [15:0] v);
      return longint'($signed(v));
   endfunction

   task automatic predict_extrusion();
      bit f;
      longint ax, ay, bx, by, cx, cy;
      vec_type ab, ac, cb, nab, nac, ncb;
      vec_type tv[3], ev[3];
      longint h[3];
      bit eab, ebc, eca;
      corner_type c;
      f = 0;
      ax = coord(req_point_a[31:16]);
      ay = coord(req_point_a[15:0]);
      bx = coord(req_point_b[31:16]);
      by = coord(req_point_b[15:0]);
      cx = coord(req_point_c[31:16]);
      cy = coord(req_point_c[15:0]);
      ab = '{bx - ax, by - ay};
      ac = '{cx - ax, cy - ay};
      cb = '{bx - cx, by - cy};
      eab = on_outline(req_a_index, req_a_next, req_b_index, req_b_next);
      ebc = on_outline(req_b_index, req_b_next, req_c_index, req_c_next);
      eca = on_outline(req_c_index, req_c_next, req_a_index, req_a_next);
      nab = unit_normal(ab.x, ab.y, f);
      nac = unit_normal(-ac.x, -ac.y, f);
      ncb = unit_normal(-cb.x, -cb.y, f);
      tv[0] = corner_vec(eab, eca, nab, nac, ac, ab, f);
      tv[1] = corner_vec(eab, ebc, nab, ncb, cb, ab, f);
      tv[2] = corner_vec(eca, ebc, nac, ncb, cb, ac, f);
      ev[0] = miter(nab, nac, f);
      ev[1] = miter(nab, ncb, f);
      ev[2] = miter(nac, ncb, f);
      h[0] = height_of(ncb, tv[0], f);
      h[1] = height_of(nac, tv[1], f);
      h[2] = height_of(nab, tv[2], f);
      for (int k = 0; k < 3; k++) begin
         c.slot = 2'(k);
         c.last = k == 2;
         c.glyph_end = req_final_triangle;
         c.tri_x = tv[k].x[23:0];
         c.tri_y = tv[k].y[23:0];
         c.edge_x = ev[k].x[23:0];
         c.edge_y = ev[k].y[23:0];
         c.height = h[k][23:0];
         c.ab_ext = eab;
         c.bc_ext = ebc;
         c.ca_ext = eca;
         c.sat = f;
         expected_corners.push_back(c);
      end
   endtask

   // ---------------- accept and check ----------------
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         if (typed_zero) begin
            // all corners coincide and no edge is exterior: every vector is zero
            for (int k = 0; k < 3; k++)
               expected_corners.push_back('{2'(k), k == 2, req_final_triangle, 0, 0, 0, 0, 0,
                                            0, 0, 0, 1});
         end else begin
            predict_extrusion();
         end
         beats_taken++;
      end
   end

   task automatic check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $display("%0t: mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      corner_type e;
      if (!reset && rsp_valid) begin
         if (expected_corners.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual slot %0d",
                     $time, rsp_corner_slot);
            errors++;
         end else begin
            e = expected_corners.pop_front();
            check_field("corner_slot", e.slot, rsp_corner_slot);
            check_field("corner_last", e.last, rsp_corner_last);
            check_field("glyph_end", e.glyph_end, rsp_glyph_end);
            check_field("tri_normal_x", e.tri_x, rsp_tri_normal_x);
            check_field("tri_normal_y", e.tri_y, rsp_tri_normal_y);
            check_field("edge_normal_x", e.edge_x, rsp_edge_normal_x);
            check_field("edge_normal_y", e.edge_y, rsp_edge_normal_y);
            check_field("height_factor", e.height, rsp_height_factor);
            check_field("ab_exterior", e.ab_ext, rsp_ab_exterior);
            check_field("bc_exterior", e.bc_ext, rsp_bc_exterior);
            check_field("ca_exterior", e.ca_ext, rsp_ca_exterior);
            check_field("saturated", e.sat, rsp_saturated);
         end
      end
   end

   // ---------------- stimulus ----------------
   task automatic send_triangle(tri_row_type r);
      int target;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_point_a <= r.pa;
      req_point_b <= r.pb;
      req_point_c <= r.pc;
      req_a_index <= r.ia;
      req_a_next <= r.na;
      req_b_index <= r.ib;
      req_b_next <= r.nb;
      req_c_index <= r.ic;
      req_c_next <= r.nc;
      req_final_triangle <= r.fin;
      typed_zero <= r.typed;
      target = beats_taken + 1;
      do @(negedge clock); while (beats_taken < target);
   endtask

   function automatic logic [31:0] small_point();
      logic [15:0] x, y;
      x = 16'($signed($urandom_range(8192)) - 4096);
      y = 16'($signed($urandom_range(8192)) - 4096);
      return {x, y};
   endfunction

   function automatic tri_row_type random_triangle();
      tri_row_type r;
      int base;
      r.typed = 0;
      r.fin = 1'($urandom_range(1));
      if ($urandom_range(99) < 20) begin
         r.pa = $urandom;
         r.pb = $urandom;
         r.pc = $urandom;
      end else begin
         r.pa = small_point();
         r.pb = small_point();
         r.pc = small_point();
      end
      if ($urandom_range(99) < 75) begin
         // consecutive outline run with random edges broken into the interior
         base = $urandom_range(1020);
         r.ia = 11'(base);
         r.na = 11'(base + 1);
         r.ib = 11'(base + 1);
         r.nb = 11'(base + 2);
         r.ic = 11'(base + 2);
         r.nc = 11'($urandom_range(1) ? base : base + 3);
         if ($urandom_range(3) == 0) r.ia = -11'sd1;
         if ($urandom_range(3) == 0) r.ib = -11'sd1;
         if ($urandom_range(3) == 0) r.ic = -11'sd1;
      end else begin
         r.ia = 11'($urandom);
         r.na = 11'($urandom);
         r.ib = 11'($urandom);
         r.nb = 11'($urandom);
         r.ic = 11'($urandom);
         r.nc = 11'($urandom);
      end
      return r;
   endfunction

   tri_row_type directed_rows[] = '{
      '{32'h0, 32'h0, 32'h0, -1, -1, -1, -1, -1, -1, 1'b0, 1'b1},
      '{32'h12345678, 32'h12345678, 32'h12345678, -1024, 5, -1024, 7, -1024, 9, 1'b1, 1'b1},
      '{32'h0000_0000, 32'h1000_0000, 32'h0000_1000, 0, 1, 1, 2, 2, 0, 1'b0, 1'b0},
      '{32'h0000_0000, 32'h1000_0000, 32'h0000_1000, 0, 1, 1, 2, -1, 0, 1'b0, 1'b0},
      '{32'h0000_0000, 32'h1000_0000, 32'h0000_1000, 0, 1, 1, 5, -1, 0, 1'b1, 1'b0},
      '{32'h0000_0000, 32'h1000_0000, 32'h0000_1000, -1, 1, 1, 2, 2, 0, 1'b0, 1'b0},
      '{32'h0000_0000, 32'h1000_0000, 32'h2000_0000, 0, 1, 1, 2, 2, 0, 1'b0, 1'b0},
      '{32'h0000_0000, 32'h0001_0000, 32'h0000_0001, 0, 1, 1, 2, 2, 0, 1'b0, 1'b0},
      '{32'h7FFF_7FFF, 32'h8000_8000, 32'h7FFF_8000, 1021, 1022, 1022, 1023, 1023, 1021,
        1'b1, 1'b0},
      '{32'h8000_8000, 32'h7FFF_8000, 32'h8000_7FFF, 1023, 1022, 1022, 1021, 1021, 1023,
        1'b0, 1'b0},
      '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_0000, 1023, -1024, 0, 1023, -1, 0,
        1'b0, 1'b0},
      '{32'h0000_0000, 32'h1000_0000, 32'h1000_0000, 3, 4, 4, 5, 5, 3, 1'b0, 1'b0},
      '{32'h0000_0000, 32'h0800_0001, 32'hF800_0001, 3, 4, 4, 5, 5, 3, 1'b0, 1'b0},
      '{32'h1000_1000, 32'h1000_1000, 32'h2000_0000, 8, 9, 9, 10, 10, 8, 1'b1, 1'b0},
      '{32'h0000_0000, 32'h1000_0000, 32'h0000_1000, 0, 1023, 1023, 1022, 1022, 0,
        1'b0, 1'b0},
      '{32'h0000_0000, 32'h1000_0000, 32'h0000_1000, 0, -1024, -1, 0, 5, 6, 1'b0, 1'b0}
   };

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idle_pct = 37;
      foreach (directed_rows[i]) send_triangle(directed_rows[i]);
      for (int n = 0; n < 280; n++) begin
         if (n == 95) idle_pct = 81;
         if (n == 190) idle_pct = 0;
         if (n == 140) begin
            // hold off until every expected result beat has been checked
            start <= 1'b0;
            @(negedge clock);
            while (expected_corners.size() != 0) @(negedge clock);
         end
         send_triangle(random_triangle());
      end
      start <= 1'b0;
      typed_zero <= 1'b0;
      while (expected_corners.size() != 0) @(negedge clock);
      repeat (Settle) @(negedge clock);
      if (errors == 0 && expected_corners.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
